### hdl/tip_pkg.sv
// Shared types, constants and CRC helper for the tag inventory frame parser.
`default_nettype none

package tip_pkg;

  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h8408;

  localparam logic [7:0] StatusOk   = 8'd1;
  localparam logic [7:0] PosStatus  = 8'd3;
  localparam logic [7:0] PosTagCnt  = 8'd4;
  localparam logic [7:0] PosFirstTag = 8'd5;
  localparam logic [7:0] MinLength  = 8'd5;
  localparam logic [7:0] MinCrcLength = 8'd2;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_TAG_LEN = 2'd2,
    PH_EPC     = 2'd3
  } phase_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] epc_byte;
    logic [7:0] tag_number;
    logic       epc_last;
    logic [7:0] tags_found;
    logic       status_good;
    logic       crc_match;
    logic       malformed;
  } tip_result_t;

  // Reflected CRC-16, one byte folded in, LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/tip_parse_core.sv
// Frame parse state, CRC accumulator and per-byte result logic.
`default_nettype none

module tip_parse_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire  [7:0]          byte_i,
  output tip_pkg::tip_result_t res_o
);
  import tip_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  tags_q, tags_d;
  logic [7:0]  epc_q, epc_d;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        status_q, status_d;
  logic        err_q, err_d;

  logic [7:0]  p;
  logic        in_body;
  logic        last;
  logic        err_end;
  tip_result_t res;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    pos_d    = pos_q;
    tags_d   = tags_q;
    epc_d    = epc_q;
    tag_d    = tag_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    status_d = status_q;
    err_d    = err_q;
    res      = '0;
    p        = pos_q + 8'd1;
    in_body  = (len_q >= MinCrcLength) && (p <= len_q - 8'd2);
    last     = 1'b0;
    err_end  = 1'b0;

    if (phase_q == PH_WAIT) begin
      // Length byte opens a new frame.
      len_d    = byte_i;
      pos_d    = 8'd0;
      tags_d   = 8'd0;
      epc_d    = 8'd0;
      tag_d    = 8'd0;
      crc_d    = (byte_i >= MinCrcLength) ? crc_fold(CrcPreset, byte_i) : CrcPreset;
      crc_lo_d = 8'd0;
      status_d = 1'b0;
      err_d    = (byte_i < MinLength);
      if (byte_i == 8'd0) begin
        res.valid     = 1'b1;
        res.kind      = KIND_SUMMARY;
        res.malformed = 1'b1;
      end else begin
        phase_d = PH_HEADER;
      end
    end else begin
      pos_d = p;
      if (in_body) begin
        crc_d = crc_fold(crc_q, byte_i);
        if (p == PosStatus) begin
          status_d = (byte_i == StatusOk);
        end else if (p == PosTagCnt) begin
          if (status_q) begin
            tags_d  = byte_i;
            phase_d = PH_TAG_LEN;
          end
        end else if (p >= PosFirstTag && status_q) begin
          if (phase_q == PH_TAG_LEN && tags_q != 8'd0) begin
            epc_d = byte_i;
            if (byte_i == 8'd0) begin
              // empty EPC still counts as a tag
              tag_d  = tag_q + 8'd1;
              tags_d = tags_q - 8'd1;
            end else begin
              phase_d = PH_EPC;
            end
          end else if (phase_q == PH_EPC && epc_q != 8'd0) begin
            epc_d = epc_q - 8'd1;
            last  = (epc_q == 8'd1);
            if (last) begin
              tag_d = tag_q + 8'd1;
              if (tags_q != 8'd0) begin
                tags_d = tags_q - 8'd1;
              end
              phase_d = PH_TAG_LEN;
            end
            res.valid      = 1'b1;
            res.kind       = KIND_DATA;
            res.epc_byte   = byte_i;
            res.tag_number = tag_q;
            res.epc_last   = last;
          end
        end
      end else if (p == len_q - 8'd1) begin
        crc_lo_d = byte_i;
      end else begin
        // CRC high byte closes the frame
        err_end           = err_q | (status_q && tags_q != 8'd0);
        err_d             = err_end;
        res.valid         = 1'b1;
        res.kind          = KIND_SUMMARY;
        res.tags_found    = status_q ? tag_q : 8'd0;
        res.status_good   = status_q;
        res.crc_match     = (len_q >= MinCrcLength) && (crc_q == {byte_i, crc_lo_q});
        res.malformed     = err_end;
        phase_d           = PH_WAIT;
      end
    end
  end

  assign res_o = step_i ? res : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      len_q    <= 8'd0;
      pos_q    <= 8'd0;
      tags_q   <= 8'd0;
      epc_q    <= 8'd0;
      tag_q    <= 8'd0;
      crc_q    <= CrcPreset;
      crc_lo_q <= 8'd0;
      status_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      tags_q   <= tags_d;
      epc_q    <= epc_d;
      tag_q    <= tag_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      status_q <= status_d;
      err_q    <= err_d;
    end
  end

  a_data_needs_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_DATA) |-> status_q)
    else $error("EPC byte emitted without good status");

  a_summary_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_SUMMARY) |=> (phase_q == PH_WAIT))
    else $error("frame not closed after summary");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_WAIT) |-> (pos_q < len_q))
    else $error("byte position past frame end");

  a_epc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EPC) |-> (tags_q != 8'd0 && epc_q != 8'd0))
    else $error("EPC phase with nothing left to receive");

endmodule

`default_nettype wire

### hdl/tag_inventory_frame_parser.sv
// Top level: byte input register, parse core and result output register.
`default_nettype none

// Reader inventory response parser. Bytes of a response frame arrive one per
// transfer on the slave side, starting with the length byte L; the frame
// ends with the CRC high byte at position L. While the status byte equals 1,
// every EPC byte leaves as a data transfer (tuser = 0) with its tag number
// and tlast on the final byte of that tag's EPC. The CRC high byte (or a zero
// length byte) yields one summary transfer (tuser = 1) with tags found,
// status, CRC match against the reflected CRC-16 (poly 0x8408, preset
// 0xFFFF) and a malformed flag. Throughput is one byte per clock unless a full
// output register stalls; a byte's result goes from the input register into
// the output register. The rate is set by the parse state loop, which folds
// one whole byte into the CRC and updates the tag counters per step. The slave
// side stays ready as long as the output register is empty or being drained.
module tag_inventory_frame_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] epc_byte, [15:8] tag_number,
                                        // [23:16] tags_found, [24] status_good,
                                        // [25] crc_match, [26] malformed
  output logic        m_axis_tlast_o,   // epc_last
  output logic        m_axis_tuser_o    // kind
);
  import tip_pkg::*;

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  // output register
  logic        out_valid_q;
  tip_result_t out_q;

  logic        advance;
  tip_result_t res;

  // The held byte moves into the core when the output slot is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  tip_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.malformed, out_q.crc_match, out_q.status_good,
                            out_q.tags_found, out_q.tag_number, out_q.epc_byte};
  assign m_axis_tlast_o  = out_q.epc_last;
  assign m_axis_tuser_o  = out_q.kind;

endmodule

`default_nettype wire
